[design/obtc_pkg.sv]
package obtc_pkg;

    localparam int FRAC_BITS = 16;

    localparam int RAW_W   = 21;
    localparam int TIME_W  = 32;
    localparam int SLOPE_W = 18;
    localparam int OFF_W   = 21;
    localparam int DB_W    = 16;
    localparam int MINC_W  = 10;
    localparam int OUT_W   = 23;
    localparam int PROD_W  = SLOPE_W + RAW_W;
    localparam int MQ_W    = PROD_W - FRAC_BITS + 1;
    localparam int EXT_W   = MQ_W + 2;

    localparam int APB_AW  = 5;
    localparam int APB_DW  = 32;

    localparam logic [2:0] REG_SLOPE_FALL   = 3'd0;
    localparam logic [2:0] REG_OFFSET_FALL  = 3'd1;
    localparam logic [2:0] REG_SLOPE_RISE   = 3'd2;
    localparam logic [2:0] REG_OFFSET_RISE  = 3'd3;
    localparam logic [2:0] REG_DEADBAND     = 3'd4;
    localparam logic [2:0] REG_BASE_TIME    = 3'd5;
    localparam logic [2:0] REG_MIN_COUNT    = 3'd6;
    localparam logic [2:0] REG_START_TIME   = 3'd7;

    localparam logic [SLOPE_W-1:0]       RST_SLOPE_FALL  = 18'd63177;
    localparam logic signed [OFF_W-1:0]  RST_OFFSET_FALL = 21'sd80282;
    localparam logic [SLOPE_W-1:0]       RST_SLOPE_RISE  = 18'd69114;
    localparam logic signed [OFF_W-1:0]  RST_OFFSET_RISE = -21'sd72076;
    localparam logic [DB_W-1:0]          RST_DEADBAND    = 16'd131;
    localparam logic [TIME_W-1:0]        RST_BASE_TIME   = 32'd120000;
    localparam logic [MINC_W-1:0]        RST_MIN_COUNT   = 10'd10;
    localparam logic [TIME_W-1:0]        RST_START_TIME  = 32'd0;

    localparam logic signed [EXT_W-1:0] OUT_LO = -26'sd1048576;
    localparam logic signed [EXT_W-1:0] OUT_HI = 26'sd3145728;
    localparam logic signed [EXT_W-1:0] OFF_LO = -26'sd1048576;
    localparam logic signed [EXT_W-1:0] OFF_HI = 26'sd1048575;

    typedef struct packed {
        logic [SLOPE_W-1:0]       slope_fall;
        logic signed [OFF_W-1:0]  offset_fall_base;
        logic [SLOPE_W-1:0]       slope_rise;
        logic signed [OFF_W-1:0]  offset_rise_base;
        logic [DB_W-1:0]          trend_deadband;
        logic [TIME_W-1:0]        baseline_time_ms;
        logic [MINC_W-1:0]        min_baseline_count;
        logic [TIME_W-1:0]        start_time_ms;
    } cfg_t;

    typedef struct packed {
        logic load;
        logic mul_item;
        logic add_item;
        logic acc;
        logic check;
        logic div_raw_go;
        logic take_raw;
        logic div_cor_go;
        logic take_cor;
        logic mul_fall_anchor;
        logic set_fall;
        logic mul_rise_anchor;
        logic set_rise;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic item_dyn;
        logic lock_hit;
        logic div_busy;
        logic out_free;
    } sts_t;

    // (slope * x + half LSB) >> FRAC_BITS
    function automatic logic [MQ_W-1:0] mul_round(input logic [PROD_W-1:0] p);
        logic [PROD_W:0] t;
        t = {1'b0, p} + (PROD_W + 1)'(1 << (FRAC_BITS - 1));
        return t[PROD_W:FRAC_BITS];
    endfunction

    function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [EXT_W-1:0] v);
        logic signed [EXT_W-1:0] r;
        r = (v < OUT_LO) ? OUT_LO : ((v > OUT_HI) ? OUT_HI : v);
        return OUT_W'(r);
    endfunction

    function automatic logic signed [OFF_W-1:0] sat_off(input logic signed [EXT_W-1:0] v);
        logic signed [EXT_W-1:0] r;
        r = (v < OFF_LO) ? OFF_LO : ((v > OFF_HI) ? OFF_HI : v);
        return OFF_W'(r);
    endfunction

endpackage

[design/oxygen_baseline_trend_correction_top.sv]
// Oxygen baseline and trend correction. Each request carries a raw Q16 oxygen
// reading and a millisecond timestamp and yields exactly one result. During the
// baseline phase the falling line corrects the sample and raw and corrected sums
// accumulate; once the elapsed time reaches baseline_time_ms with more than
// min_baseline_count samples, the rounded means re-anchor both line offsets and
// the block enters the dynamic phase, where a deadband trend detector picks the
// rising or falling line. One request is processed at a time, and the locking
// request also waits on the bit-serial divider that forms the two means one after
// the other. A result held in the output register does not block the next
// request until that request is ready to leave.
module oxygen_baseline_trend_correction_top #(
    parameter int COUNT_WIDTH = 20
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [55:0]                 s_tdata,  // raw_o2[20:0], now_ms[52:21], zero pad
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [23:0]                 m_tdata,  // corrected_o2[22:0], zero pad
    output logic [2:0]                  m_tuser,  // in_dynamic, trend_rising, baseline_locked_now
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [obtc_pkg::APB_AW-1:0] paddr,
    input  logic [obtc_pkg::APB_DW-1:0] pwdata,
    output logic [obtc_pkg::APB_DW-1:0] prdata,
    output logic                        pready
);
    import obtc_pkg::*;

    cfg_t                    cfg;
    cmd_t                    cmd;
    sts_t                    sts;
    logic signed [OUT_W-1:0] corr;
    logic                    dyn;
    logic                    rising;
    logic                    locked;

    obtc_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg_o   (cfg)
    );

    obtc_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid_i (s_tvalid),
        .s_ready_o (s_tready),
        .sts_i     (sts),
        .cmd_o     (cmd)
    );

    obtc_dpath #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dpath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_i      (cfg),
        .cmd_i      (cmd),
        .sts_o      (sts),
        .raw_i      (s_tdata[RAW_W-1:0]),
        .now_i      (s_tdata[RAW_W+TIME_W-1:RAW_W]),
        .m_valid_o  (m_tvalid),
        .m_ready_i  (m_tready),
        .m_corr_o   (corr),
        .m_dyn_o    (dyn),
        .m_rising_o (rising),
        .m_locked_o (locked)
    );

    assign m_tdata = {1'b0, corr};
    assign m_tuser = {locked, rising, dyn};

`ifndef ASSERT_OFF
    a_lock_in_baseline: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[2] |-> !m_tuser[0])
        else $error("lock flagged on a dynamic-phase result");

    a_rising_only_dynamic: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> !m_tuser[1])
        else $error("rising line reported in baseline phase");

    a_out_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[22:0]) <= 23'sd3145728) && !m_tdata[23])
        else $error("corrected value out of range");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while busy");
`endif

endmodule

[design/obtc_regs.sv]
module obtc_regs (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [obtc_pkg::APB_AW-1:0] paddr,
    input  logic [obtc_pkg::APB_DW-1:0] pwdata,
    output logic [obtc_pkg::APB_DW-1:0] prdata,
    output logic                        pready,
    output obtc_pkg::cfg_t              cfg_o
);
    import obtc_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [2:0] idx;
    logic       wr_en;

    assign idx    = paddr[4:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg_o  = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (idx)
                REG_SLOPE_FALL:  cfg_next.slope_fall         = pwdata[SLOPE_W-1:0];
                REG_OFFSET_FALL: cfg_next.offset_fall_base   = $signed(pwdata[OFF_W-1:0]);
                REG_SLOPE_RISE:  cfg_next.slope_rise         = pwdata[SLOPE_W-1:0];
                REG_OFFSET_RISE: cfg_next.offset_rise_base   = $signed(pwdata[OFF_W-1:0]);
                REG_DEADBAND:    cfg_next.trend_deadband     = pwdata[DB_W-1:0];
                REG_BASE_TIME:   cfg_next.baseline_time_ms   = pwdata[TIME_W-1:0];
                REG_MIN_COUNT:   cfg_next.min_baseline_count = pwdata[MINC_W-1:0];
                REG_START_TIME:  cfg_next.start_time_ms      = pwdata[TIME_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.slope_fall         <= RST_SLOPE_FALL;
            cfg_reg.offset_fall_base   <= RST_OFFSET_FALL;
            cfg_reg.slope_rise         <= RST_SLOPE_RISE;
            cfg_reg.offset_rise_base   <= RST_OFFSET_RISE;
            cfg_reg.trend_deadband     <= RST_DEADBAND;
            cfg_reg.baseline_time_ms   <= RST_BASE_TIME;
            cfg_reg.min_baseline_count <= RST_MIN_COUNT;
            cfg_reg.start_time_ms      <= RST_START_TIME;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        unique case (idx)
            REG_SLOPE_FALL:  prdata = APB_DW'(cfg_reg.slope_fall);
            REG_OFFSET_FALL: prdata = APB_DW'(cfg_reg.offset_fall_base);
            REG_SLOPE_RISE:  prdata = APB_DW'(cfg_reg.slope_rise);
            REG_OFFSET_RISE: prdata = APB_DW'(cfg_reg.offset_rise_base);
            REG_DEADBAND:    prdata = APB_DW'(cfg_reg.trend_deadband);
            REG_BASE_TIME:   prdata = cfg_reg.baseline_time_ms;
            REG_MIN_COUNT:   prdata = APB_DW'(cfg_reg.min_baseline_count);
            REG_START_TIME:  prdata = cfg_reg.start_time_ms;
            default:         prdata = '0;
        endcase
    end

endmodule

[design/obtc_div.sv]
module obtc_div #(
    parameter int DVD_W = 43,
    parameter int DVS_W = 20
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start_i,
    input  logic [DVD_W-1:0] dividend_i,
    input  logic [DVS_W-1:0] divisor_i,
    output logic             busy_o,
    output logic [DVD_W-1:0] quotient_o
);
    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] q_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;

    logic [DVS_W:0]   shifted;
    logic [DVS_W:0]   diff;
    logic             ge;

    assign shifted    = {rem_reg, q_reg[DVD_W-1]};
    assign ge         = shifted >= {1'b0, dvs_reg};
    assign diff       = shifted - {1'b0, dvs_reg};
    assign busy_o     = busy_reg;
    assign quotient_o = q_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start_i) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(DVD_W);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start_i) begin
            q_reg   <= dividend_i;
            rem_reg <= '0;
            dvs_reg <= divisor_i;
        end else if (busy_reg) begin
            q_reg   <= {q_reg[DVD_W-2:0], ge};
            rem_reg <= ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
        end
    end

endmodule

[design/obtc_dpath.sv]
module obtc_dpath #(
    parameter int COUNT_WIDTH = 20
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  obtc_pkg::cfg_t                    cfg_i,
    input  obtc_pkg::cmd_t                    cmd_i,
    output obtc_pkg::sts_t                    sts_o,
    input  logic [obtc_pkg::RAW_W-1:0]        raw_i,
    input  logic [obtc_pkg::TIME_W-1:0]       now_i,
    output logic                              m_valid_o,
    input  logic                              m_ready_i,
    output logic signed [obtc_pkg::OUT_W-1:0] m_corr_o,
    output logic                              m_dyn_o,
    output logic                              m_rising_o,
    output logic                              m_locked_o
);
    import obtc_pkg::*;

    localparam int RSUM_W = COUNT_WIDTH + 22;
    localparam int CSUM_W = COUNT_WIDTH + 24;
    localparam int DVD_W  = COUNT_WIDTH + 23;

    logic [RAW_W-1:0]         raw_reg;
    logic [TIME_W-1:0]        now_reg;
    logic                     item_dyn_reg;
    logic [PROD_W-1:0]        prod_reg;
    logic signed [OUT_W-1:0]  c_reg;
    logic                     locked_reg;
    logic                     phase_reg;
    logic                     trend_reg;
    logic [RAW_W-1:0]         prev_reg;
    logic [RSUM_W-1:0]        rsum_reg;
    logic signed [CSUM_W-1:0] csum_reg;
    logic [COUNT_WIDTH-1:0]   cnt_reg;
    logic signed [OFF_W-1:0]  fall_act_reg;
    logic signed [OFF_W-1:0]  rise_act_reg;
    logic [RAW_W-1:0]         base_raw_reg;
    logic signed [OUT_W-1:0]  base_true_reg;
    logic                     cor_neg_reg;

    logic                     out_valid_reg;
    logic signed [OUT_W-1:0]  out_corr_reg;
    logic                     out_dyn_reg;
    logic                     out_rising_reg;
    logic                     out_locked_reg;

    logic [RAW_W:0]           raw_plus_db;
    logic [RAW_W:0]           prev_plus_db;
    logic                     trend_new;
    logic [SLOPE_W-1:0]       mul_a;
    logic [RAW_W-1:0]         mul_b;
    logic [MQ_W-1:0]          mq;
    logic signed [OFF_W-1:0]  off_sel;
    logic signed [EXT_W-1:0]  c_ext;
    logic signed [EXT_W-1:0]  anchor_ext;
    logic                     lock_hit;
    logic [TIME_W-1:0]        elapsed;
    logic [DVD_W-1:0]         half_cnt;
    logic                     csum_neg;
    logic [CSUM_W-1:0]        csum_inv;
    logic                     div_start;
    logic [DVD_W-1:0]         div_dvd;
    logic                     div_busy;
    logic [DVD_W-1:0]         div_quo;
    logic                     out_free;

    // trend decision against the previous sample
    assign raw_plus_db  = {1'b0, raw_i} + (RAW_W + 1)'(cfg_i.trend_deadband);
    assign prev_plus_db = {1'b0, prev_reg} + (RAW_W + 1)'(cfg_i.trend_deadband);
    always_comb begin
        if (raw_plus_db < {1'b0, prev_reg}) begin
            trend_new = 1'b0;
        end else if ({1'b0, raw_i} > prev_plus_db) begin
            trend_new = 1'b1;
        end else begin
            trend_new = trend_reg;
        end
    end

    always_comb begin
        mul_a = cfg_i.slope_fall;
        mul_b = raw_reg;
        if (cmd_i.mul_fall_anchor) begin
            mul_b = base_raw_reg;
        end else if (cmd_i.mul_rise_anchor) begin
            mul_a = cfg_i.slope_rise;
            mul_b = base_raw_reg;
        end else if (item_dyn_reg && trend_reg) begin
            mul_a = cfg_i.slope_rise;
        end
    end

    assign mq = mul_round(prod_reg);

    always_comb begin
        if (!item_dyn_reg) begin
            off_sel = cfg_i.offset_fall_base;
        end else if (trend_reg) begin
            off_sel = rise_act_reg;
        end else begin
            off_sel = fall_act_reg;
        end
    end

    assign c_ext      = $signed({2'b00, mq}) + EXT_W'(off_sel);
    assign anchor_ext = EXT_W'(base_true_reg) - $signed({2'b00, mq});

    assign elapsed  = now_reg - cfg_i.start_time_ms;
    assign lock_hit = (elapsed >= cfg_i.baseline_time_ms) &&
                      (cnt_reg > COUNT_WIDTH'(cfg_i.min_baseline_count));

    assign half_cnt = DVD_W'(cnt_reg >> 1);
    assign csum_neg = csum_reg[CSUM_W-1];
    assign csum_inv = csum_neg ? ~csum_reg : csum_reg;

    always_comb begin
        div_start = cmd_i.div_raw_go || cmd_i.div_cor_go;
        if (cmd_i.div_cor_go) begin
            div_dvd = DVD_W'(csum_inv) + half_cnt + DVD_W'(csum_neg);
        end else begin
            div_dvd = DVD_W'(rsum_reg) + half_cnt;
        end
    end

    obtc_div #(
        .DVD_W (DVD_W),
        .DVS_W (COUNT_WIDTH)
    ) u_div (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start_i    (div_start),
        .dividend_i (div_dvd),
        .divisor_i  (cnt_reg),
        .busy_o     (div_busy),
        .quotient_o (div_quo)
    );

    assign out_free = !out_valid_reg || m_ready_i;

    assign sts_o.item_dyn = item_dyn_reg;
    assign sts_o.lock_hit = lock_hit;
    assign sts_o.div_busy = div_busy;
    assign sts_o.out_free = out_free;

    // item payload
    always_ff @(posedge aclk) begin
        if (cmd_i.load) begin
            raw_reg <= raw_i;
            now_reg <= now_i;
        end
        if (cmd_i.mul_item || cmd_i.mul_fall_anchor || cmd_i.mul_rise_anchor) begin
            prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
        end
        if (cmd_i.add_item) begin
            c_reg <= sat_out(c_ext);
        end
        if (cmd_i.div_cor_go) begin
            cor_neg_reg <= csum_neg;
        end
        if (cmd_i.take_raw) begin
            base_raw_reg <= div_quo[RAW_W-1:0];
        end
        if (cmd_i.take_cor) begin
            base_true_reg <= cor_neg_reg ? -$signed(div_quo[OUT_W-1:0])
                                         : $signed(div_quo[OUT_W-1:0]);
        end
        if (cmd_i.emit) begin
            out_corr_reg   <= c_reg;
            out_dyn_reg    <= item_dyn_reg;
            out_rising_reg <= item_dyn_reg && trend_reg;
            out_locked_reg <= locked_reg;
        end
    end

    // block state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_dyn_reg  <= 1'b0;
            locked_reg    <= 1'b0;
            phase_reg     <= 1'b0;
            trend_reg     <= 1'b0;
            prev_reg      <= '0;
            rsum_reg      <= '0;
            csum_reg      <= '0;
            cnt_reg       <= '0;
            fall_act_reg  <= RST_OFFSET_FALL;
            rise_act_reg  <= RST_OFFSET_RISE;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd_i.load) begin
                item_dyn_reg <= phase_reg;
                locked_reg   <= 1'b0;
                if (phase_reg) begin
                    trend_reg <= trend_new;
                end
            end
            if (cmd_i.acc && (cnt_reg != '1)) begin
                rsum_reg <= rsum_reg + RSUM_W'(raw_reg);
                csum_reg <= csum_reg + CSUM_W'(c_reg);
                cnt_reg  <= cnt_reg + 1'b1;
            end
            if (cmd_i.check) begin
                locked_reg <= lock_hit;
            end
            if (cmd_i.set_fall) begin
                fall_act_reg <= sat_off(anchor_ext);
            end
            if (cmd_i.set_rise) begin
                rise_act_reg <= sat_off(anchor_ext);
            end
            if (cmd_i.emit) begin
                out_valid_reg <= 1'b1;
                if (locked_reg) begin
                    phase_reg <= 1'b1;
                    trend_reg <= 1'b0;
                    prev_reg  <= raw_reg;
                end else if (item_dyn_reg) begin
                    prev_reg <= raw_reg;
                end
            end else if (m_ready_i) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid_o  = out_valid_reg;
    assign m_corr_o   = out_corr_reg;
    assign m_dyn_o    = out_dyn_reg;
    assign m_rising_o = out_rising_reg;
    assign m_locked_o = out_locked_reg;

endmodule

[design/obtc_ctrl.sv]
module obtc_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid_i,
    output logic           s_ready_o,
    input  obtc_pkg::sts_t sts_i,
    output obtc_pkg::cmd_t cmd_o
);
    import obtc_pkg::*;

    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_MUL       = 4'd1;
    localparam logic [3:0] ST_ADD       = 4'd2;
    localparam logic [3:0] ST_ACC       = 4'd3;
    localparam logic [3:0] ST_CHK       = 4'd4;
    localparam logic [3:0] ST_DIVR_GO   = 4'd5;
    localparam logic [3:0] ST_DIVR_WAIT = 4'd6;
    localparam logic [3:0] ST_DIVC_GO   = 4'd7;
    localparam logic [3:0] ST_DIVC_WAIT = 4'd8;
    localparam logic [3:0] ST_MUL_FALL  = 4'd9;
    localparam logic [3:0] ST_SET_FALL  = 4'd10;
    localparam logic [3:0] ST_MUL_RISE  = 4'd11;
    localparam logic [3:0] ST_SET_RISE  = 4'd12;
    localparam logic [3:0] ST_EMIT      = 4'd13;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign s_ready_o = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd_o      = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid_i) begin
                    cmd_o.load = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd_o.mul_item = 1'b1;
                state_next     = ST_ADD;
            end
            ST_ADD: begin
                cmd_o.add_item = 1'b1;
                state_next     = sts_i.item_dyn ? ST_EMIT : ST_ACC;
            end
            ST_ACC: begin
                cmd_o.acc  = 1'b1;
                state_next = ST_CHK;
            end
            ST_CHK: begin
                cmd_o.check = 1'b1;
                state_next  = sts_i.lock_hit ? ST_DIVR_GO : ST_EMIT;
            end
            ST_DIVR_GO: begin
                cmd_o.div_raw_go = 1'b1;
                state_next       = ST_DIVR_WAIT;
            end
            ST_DIVR_WAIT: begin
                if (!sts_i.div_busy) begin
                    cmd_o.take_raw = 1'b1;
                    state_next     = ST_DIVC_GO;
                end
            end
            ST_DIVC_GO: begin
                cmd_o.div_cor_go = 1'b1;
                state_next       = ST_DIVC_WAIT;
            end
            ST_DIVC_WAIT: begin
                if (!sts_i.div_busy) begin
                    cmd_o.take_cor = 1'b1;
                    state_next     = ST_MUL_FALL;
                end
            end
            ST_MUL_FALL: begin
                cmd_o.mul_fall_anchor = 1'b1;
                state_next            = ST_SET_FALL;
            end
            ST_SET_FALL: begin
                cmd_o.set_fall = 1'b1;
                state_next     = ST_MUL_RISE;
            end
            ST_MUL_RISE: begin
                cmd_o.mul_rise_anchor = 1'b1;
                state_next            = ST_SET_RISE;
            end
            ST_SET_RISE: begin
                cmd_o.set_rise = 1'b1;
                state_next     = ST_EMIT;
            end
            ST_EMIT: begin
                if (sts_i.out_free) begin
                    cmd_o.emit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
